// File: src/rcbp_pkg.sv
// Shared types and constants for the remote command byte parser.
`timescale 1ns / 1ps
`default_nettype none

package rcbp_pkg;

  localparam int unsigned FRAME_CAPACITY = 50;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned HORNER_W = VALUE_W + 4;

  // received byte codes
  localparam logic [7:0] BYTE_STOP_TOGGLE = 8'h61;
  localparam logic [7:0] BYTE_CTRL_MAX    = 8'd10;
  localparam logic [7:0] BYTE_BRAKE       = 8'h5A;
  localparam logic [7:0] BYTE_FORWARD     = 8'h41;
  localparam logic [7:0] BYTE_BACK        = 8'h45;
  localparam logic [7:0] BYTE_RIGHT_LO    = 8'h42;
  localparam logic [7:0] BYTE_RIGHT_HI    = 8'h44;
  localparam logic [7:0] BYTE_LEFT_LO     = 8'h46;
  localparam logic [7:0] BYTE_LEFT_HI     = 8'h48;
  localparam logic [7:0] BYTE_OPEN        = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE       = 8'h7D;
  localparam logic [7:0] BYTE_REPORT      = 8'h50;
  localparam logic [7:0] BYTE_NO_GAIN     = 8'h23;
  localparam logic [7:0] BYTE_ID_LO       = 8'h30;
  localparam logic [7:0] BYTE_ID_HI       = 8'h35;
  localparam logic [7:0] DIGIT_BASE       = 8'd48;

  // frame byte positions
  localparam logic [COUNT_W-1:0] POS_ID     = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_FOURTH = COUNT_W'(3);

  typedef enum logic [2:0] {
    DRIVE_BRAKE   = 3'd0,
    DRIVE_FORWARD = 3'd1,
    DRIVE_BACK    = 3'd2,
    DRIVE_RIGHT   = 3'd3,
    DRIVE_LEFT    = 3'd4
  } drive_t;

  typedef struct packed {
    logic                      gain_write;
    logic [2:0]                gain_select;
    logic signed [VALUE_W-1:0] gain_value;
    logic                      report_request;
  } frame_result_t;

endpackage

`default_nettype wire

// File: src/remote_command_byte_parser.sv
// Top level of the remote command byte parser with its result register.
//
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per beat.
// Output channel: out_valid / out_ready carry one result beat per input beat:
//   stop_flag, drive_cmd, gain_write, gain_select, gain_value, report_request.
// Each byte updates the stop toggle, the drive command and the frame state
// ('{' opens, '}' closes; close writes a gain or raises a report request).
// The result for a byte is registered and is on the output in the cycle after its beat.
// Throughput: one byte per cycle unless the receiver stalls; the decode and the saturating Horner step
//   (acc*10 + digit, one 36-bit add and clamp) fit between the state
//   registers and the result register.
// The result register holds while out_ready is low; in_ready stays high
//   whenever the result register is empty or is being drained in the same
//   cycle, so a steady stream runs back to back without bubbles.
// If the receiver stalls with a result pending, in_ready drops and the
//   byte state is frozen until the result beat is taken.
// Reset (rst, synchronous): stop flag off, drive brake, no frame open,
//   counters and accumulator cleared, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module remote_command_byte_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    stop_flag,
  output logic [2:0]              drive_cmd,
  output logic                    gain_write,
  output logic [2:0]              gain_select,
  output logic signed [31:0]      gain_value,
  output logic                    report_request
);

  logic                    beat;
  logic                    stop_next;
  rcbp_pkg::drive_t        drive_next;
  rcbp_pkg::frame_result_t frame_res;

  // accept when the result slot is free or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign beat     = in_valid && in_ready;

  rcbp_drive u_drive (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .rx_byte    (rx_byte),
    .stop_next  (stop_next),
    .drive_next (drive_next)
  );

  rcbp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .rx_byte (rx_byte),
    .result  (frame_res)
  );

  // result register: payload needs no reset, valid does
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      stop_flag      <= stop_next;
      drive_cmd      <= 3'(drive_next);
      gain_write     <= frame_res.gain_write;
      gain_select    <= frame_res.gain_select;
      gain_value     <= frame_res.gain_value;
      report_request <= frame_res.report_request;
    end
  end

endmodule

`default_nettype wire

// File: src/rcbp_drive.sv
// Stop toggle and drive command state with per-byte decode.
`timescale 1ns / 1ps
`default_nettype none

module rcbp_drive (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       beat,
  input  wire logic [7:0] rx_byte,
  output logic            stop_next,
  output rcbp_pkg::drive_t drive_next
);

  logic             stop_state;
  rcbp_pkg::drive_t drive_state;

  always_comb begin
    stop_next = stop_state ^ (rx_byte == rcbp_pkg::BYTE_STOP_TOGGLE);
    priority if (rx_byte <= rcbp_pkg::BYTE_CTRL_MAX) begin
      drive_next = drive_state;
    end else if (rx_byte == rcbp_pkg::BYTE_FORWARD) begin
      drive_next = rcbp_pkg::DRIVE_FORWARD;
    end else if (rx_byte == rcbp_pkg::BYTE_BACK) begin
      drive_next = rcbp_pkg::DRIVE_BACK;
    end else if (rx_byte >= rcbp_pkg::BYTE_RIGHT_LO && rx_byte <= rcbp_pkg::BYTE_RIGHT_HI) begin
      drive_next = rcbp_pkg::DRIVE_RIGHT;
    end else if (rx_byte >= rcbp_pkg::BYTE_LEFT_LO && rx_byte <= rcbp_pkg::BYTE_LEFT_HI) begin
      drive_next = rcbp_pkg::DRIVE_LEFT;
    end else begin
      drive_next = rcbp_pkg::DRIVE_BRAKE; // includes the explicit brake byte
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_state  <= 1'b0;
      drive_state <= rcbp_pkg::DRIVE_BRAKE;
    end else if (beat) begin
      stop_state  <= stop_next;
      drive_state <= drive_next;
    end
  end

endmodule

`default_nettype wire

// File: src/rcbp_frame.sv
// Frame collector: id and fourth byte capture, saturating decimal accumulate.
`timescale 1ns / 1ps
`default_nettype none

module rcbp_frame (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  beat,
  input  wire logic [7:0]            rx_byte,
  output rcbp_pkg::frame_result_t    result
);

  logic                                         collecting;
  logic [rcbp_pkg::COUNT_W-1:0]                 byte_count;
  logic [7:0]                                   id_byte;
  logic [7:0]                                   fourth_byte;
  logic signed [rcbp_pkg::VALUE_W-1:0]          accumulator;

  logic                                         collecting_next;
  logic [rcbp_pkg::COUNT_W-1:0]                 byte_count_next;
  logic [7:0]                                   id_byte_next;
  logic [7:0]                                   fourth_byte_next;
  logic signed [rcbp_pkg::VALUE_W-1:0]          accumulator_next;

  logic                                         is_close;
  logic                                         open_now;
  logic                                         store;
  logic signed [rcbp_pkg::HORNER_W-1:0]         acc_ext;
  logic signed [rcbp_pkg::HORNER_W-1:0]         horner_sum;
  logic signed [rcbp_pkg::VALUE_W-1:0]          horner_sat;

  localparam logic signed [rcbp_pkg::HORNER_W-1:0] SAT_MAX =
    rcbp_pkg::HORNER_W'(signed'({1'b0, {(rcbp_pkg::VALUE_W-1){1'b1}}}));
  localparam logic signed [rcbp_pkg::HORNER_W-1:0] SAT_MIN =
    -SAT_MAX - rcbp_pkg::HORNER_W'(1);

  // acc*10 + (byte - 48), clamped to the 32-bit range
  always_comb begin
    acc_ext    = rcbp_pkg::HORNER_W'(accumulator);
    horner_sum = (acc_ext <<< 3) + (acc_ext <<< 1)
               + signed'(rcbp_pkg::HORNER_W'(rx_byte))
               - signed'(rcbp_pkg::HORNER_W'(rcbp_pkg::DIGIT_BASE));
    if (horner_sum > SAT_MAX) begin
      horner_sat = signed'(rcbp_pkg::VALUE_W'(SAT_MAX));
    end else if (horner_sum < SAT_MIN) begin
      horner_sat = signed'(rcbp_pkg::VALUE_W'(SAT_MIN));
    end else begin
      horner_sat = signed'(horner_sum[rcbp_pkg::VALUE_W-1:0]);
    end
  end

  always_comb begin
    is_close = (rx_byte == rcbp_pkg::BYTE_CLOSE);
    open_now = collecting || (rx_byte == rcbp_pkg::BYTE_OPEN);
    store    = !is_close && open_now &&
               (byte_count < rcbp_pkg::COUNT_W'(rcbp_pkg::FRAME_CAPACITY));

    result = '0;
    if (is_close && collecting) begin
      if (fourth_byte == rcbp_pkg::BYTE_REPORT) begin
        result.report_request = 1'b1;
      end else if (id_byte != rcbp_pkg::BYTE_NO_GAIN &&
                   id_byte >= rcbp_pkg::BYTE_ID_LO && id_byte <= rcbp_pkg::BYTE_ID_HI) begin
        result.gain_write  = 1'b1;
        result.gain_select = 3'(id_byte - rcbp_pkg::BYTE_ID_LO);
        result.gain_value  = accumulator;
      end
    end

    collecting_next  = collecting;
    byte_count_next  = byte_count;
    id_byte_next     = id_byte;
    fourth_byte_next = fourth_byte;
    accumulator_next = accumulator;
    if (is_close) begin
      collecting_next  = 1'b0;
      byte_count_next  = '0;
      id_byte_next     = '0;
      fourth_byte_next = '0;
      accumulator_next = '0;
    end else begin
      collecting_next = open_now;
      if (store) begin
        if (byte_count == rcbp_pkg::POS_ID) begin
          id_byte_next = rx_byte;
        end
        if (byte_count == rcbp_pkg::POS_FOURTH) begin
          fourth_byte_next = rx_byte;
        end
        if (byte_count >= rcbp_pkg::POS_FOURTH) begin
          accumulator_next = horner_sat;
        end
        byte_count_next = byte_count + rcbp_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting  <= 1'b0;
      byte_count  <= '0;
      id_byte     <= '0;
      fourth_byte <= '0;
      accumulator <= '0;
    end else if (beat) begin
      collecting  <= collecting_next;
      byte_count  <= byte_count_next;
      id_byte     <= id_byte_next;
      fourth_byte <= fourth_byte_next;
      accumulator <= accumulator_next;
    end
  end

endmodule

`default_nettype wire
